// File: src/adpe_pkg.sv
// Shared types, opcodes and helpers for the A32 data-processing execute unit.
// No dependencies; used by the execute unit and its port checker.
package adpe_pkg;

  // Data-processing opcodes, instruction bits 24..21.
  typedef enum logic [3:0] {
    OpAnd = 4'h0,
    OpEor = 4'h1,
    OpSub = 4'h2,
    OpRsb = 4'h3,
    OpAdd = 4'h4,
    OpAdc = 4'h5,
    OpSbc = 4'h6,
    OpRsc = 4'h7,
    OpTst = 4'h8,
    OpTeq = 4'h9,
    OpCmp = 4'hA,
    OpCmn = 4'hB,
    OpOrr = 4'hC,
    OpMov = 4'hD,
    OpBic = 4'hE,
    OpMvn = 4'hF
  } op_e;

  // Condition codes, instruction bits 31..28.
  typedef enum logic [3:0] {
    CondEq = 4'h0,
    CondNe = 4'h1,
    CondCs = 4'h2,
    CondCc = 4'h3,
    CondMi = 4'h4,
    CondPl = 4'h5,
    CondVs = 4'h6,
    CondVc = 4'h7,
    CondHi = 4'h8,
    CondLs = 4'h9,
    CondGe = 4'hA,
    CondLt = 4'hB,
    CondGt = 4'hC,
    CondLe = 4'hD,
    CondAl = 4'hE,
    CondNv = 4'hF
  } cond_e;

  // Shift kinds, instruction bits 6..5.
  typedef enum logic [1:0] {
    ShLsl = 2'd0,
    ShLsr = 2'd1,
    ShAsr = 2'd2,
    ShRor = 2'd3
  } shift_e;

  // Flag positions in the NZCV nibble.
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagC = 1;
  localparam int unsigned FlagV = 0;

  localparam logic [3:0]  PcReg     = 4'hF;
  localparam logic [31:0] MovMask   = 32'h0FB0_0000;
  localparam logic [31:0] MovMatch  = 32'h0300_0000;

  function automatic logic cond_holds(cond_e cond, logic [3:0] f);
    logic n, z, c, v, r;
    n = f[FlagN];
    z = f[FlagZ];
    c = f[FlagC];
    v = f[FlagV];
    case (cond)
      CondEq:  r = z;
      CondNe:  r = !z;
      CondCs:  r = c;
      CondCc:  r = !c;
      CondMi:  r = n;
      CondPl:  r = !n;
      CondVs:  r = v;
      CondVc:  r = !v;
      CondHi:  r = c && !z;
      CondLs:  r = !c || z;
      CondGe:  r = (n == v);
      CondLt:  r = (n != v);
      CondGt:  r = !z && (n == v);
      CondLe:  r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// File: src/arm_data_processing_execute_unit.sv
// A32 data-processing execute unit: condition test, barrel shifter, ALU, flags.
// Depends on adpe_pkg for opcodes, condition codes and flag positions.

// One instruction is taken on every cycle with start high; busy is always low,
// since nothing inside can stall. Each instruction comes out as one beat marked
// by done_o, after registered stages in order: stage one tests the condition,
// decodes and runs the barrel shifter, stage two runs the 32-bit adder and the
// logic unit, stage three forms the flags and the PC write. The receiver must
// take every beat in the cycle it appears.
module arm_data_processing_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instruction_i,
  input  logic [31:0] first_operand_i,
  input  logic [31:0] shift_operand_i,
  input  logic [31:0] old_destination_i,
  input  logic [3:0]  flags_in_i,
  output logic        done_o,
  output logic [31:0] result_value_o,
  output logic [3:0]  destination_o,
  output logic        write_enable_o,
  output logic [3:0]  flags_out_o,
  output logic        condition_passed_o,
  output logic        pc_written_o,
  output logic        thumb_next_o,
  output logic        unhandled_o
);

  assign busy = 1'b0;

  // ---------------- Stage one: decode and shifter ----------------
  adpe_pkg::cond_e  cond;
  adpe_pkg::op_e    op_in;
  adpe_pkg::shift_e sh_kind;
  logic        cond_pass, is_unh, is_mov, is_dp, is_cmp, we_in;
  logic        s_in, cin;
  logic [15:0] imm16;
  logic [31:0] mov_val, op2, imm32;
  logic        shco;
  logic [4:0]  amt, rot;
  logic [63:0] rot_wide;
  logic [32:0] sh_wide;

  always_comb begin
    cond      = adpe_pkg::cond_e'(instruction_i[31:28]);
    op_in     = adpe_pkg::op_e'(instruction_i[24:21]);
    s_in      = instruction_i[20];
    cin       = flags_in_i[adpe_pkg::FlagC];
    cond_pass = (cond == adpe_pkg::CondNv) || adpe_pkg::cond_holds(cond, flags_in_i);
    is_cmp    = (op_in inside {adpe_pkg::OpTst, adpe_pkg::OpTeq,
                               adpe_pkg::OpCmp, adpe_pkg::OpCmn});
    is_unh    = 1'b0;
    is_mov    = 1'b0;
    is_dp     = 1'b0;
    if (!cond_pass) begin
      is_unh = 1'b0;
    end else if (cond == adpe_pkg::CondNv) begin
      is_unh = 1'b1;
    end else if ((instruction_i & adpe_pkg::MovMask) == adpe_pkg::MovMatch) begin
      is_mov = 1'b1;
    end else if (instruction_i[27:26] != 2'b00) begin
      is_unh = 1'b1;
    end else if ((is_cmp && !s_in) || (!instruction_i[25] && instruction_i[4]) ||
                 (op_in == adpe_pkg::OpRsc)) begin
      is_unh = 1'b1;
    end else begin
      is_dp = 1'b1;
    end
    we_in = is_mov || (is_dp && !is_cmp);

    // MOVW writes the 16-bit immediate, MOVT replaces the upper half of rd.
    imm16   = {instruction_i[19:16], instruction_i[11:0]};
    mov_val = instruction_i[22] ? {imm16, old_destination_i[15:0]} : {16'h0, imm16};

    // Rotated immediate.
    imm32    = {24'h0, instruction_i[7:0]};
    rot      = {instruction_i[11:8], 1'b0};
    rot_wide = {imm32, imm32} >> rot;

    // Immediate-amount barrel shifter.
    sh_kind = adpe_pkg::shift_e'(instruction_i[6:5]);
    amt     = instruction_i[11:7];
    sh_wide = '0;
    if (instruction_i[25]) begin
      op2  = rot_wide[31:0];
      shco = (rot != 5'd0) ? rot_wide[31] : cin;
    end else begin
      case (sh_kind)
        adpe_pkg::ShLsl: begin
          sh_wide = {1'b0, shift_operand_i} << amt;
          op2     = sh_wide[31:0];
          shco    = (amt != 5'd0) ? sh_wide[32] : cin;
        end
        adpe_pkg::ShLsr: begin
          sh_wide = {shift_operand_i, 1'b0} >> amt;
          op2     = (amt != 5'd0) ? sh_wide[32:1] : 32'h0;
          shco    = (amt != 5'd0) ? sh_wide[0] : shift_operand_i[31];
        end
        adpe_pkg::ShAsr: begin
          sh_wide = 33'($signed({shift_operand_i, 1'b0}) >>> amt);
          op2     = (amt != 5'd0) ? sh_wide[32:1] : {32{shift_operand_i[31]}};
          shco    = (amt != 5'd0) ? sh_wide[0] : shift_operand_i[31];
        end
        default: begin
          // A rotate by zero is RRX: the carry enters at the top.
          rot_wide = {shift_operand_i, shift_operand_i} >> amt;
          op2      = (amt != 5'd0) ? rot_wide[31:0] : {cin, shift_operand_i[31:1]};
          shco     = (amt != 5'd0) ? rot_wide[31] : shift_operand_i[0];
        end
      endcase
    end
  end

  logic            v1_q, pass1_q, unh1_q, mov1_q, dp1_q, we1_q, s1_q, shco1_q;
  adpe_pkg::op_e   op1_q;
  logic [3:0]      dest1_q, flags1_q;
  logic [31:0]     vn1_q, op2_1_q, movval1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    pass1_q   <= cond_pass;
    unh1_q    <= is_unh;
    mov1_q    <= is_mov;
    dp1_q     <= is_dp;
    we1_q     <= we_in;
    s1_q      <= s_in;
    shco1_q   <= shco;
    op1_q     <= op_in;
    dest1_q   <= instruction_i[15:12];
    flags1_q  <= flags_in_i;
    vn1_q     <= first_operand_i;
    op2_1_q   <= op2;
    movval1_q <= mov_val;
  end

  // ---------------- Stage two: adder and logic unit ----------------
  logic [31:0] add_a, add_b, logic_res, sum;
  logic [32:0] sum_wide;
  logic        add_c, arith, ovf;
  logic [31:0] res2_d;

  always_comb begin
    add_a     = vn1_q;
    add_b     = op2_1_q;
    add_c     = 1'b0;
    arith     = 1'b1;
    logic_res = 32'h0;
    case (op1_q)
      adpe_pkg::OpSub, adpe_pkg::OpCmp: begin
        add_b = ~op2_1_q;
        add_c = 1'b1;
      end
      adpe_pkg::OpRsb: begin
        add_a = ~vn1_q;
        add_c = 1'b1;
      end
      adpe_pkg::OpAdc: add_c = flags1_q[adpe_pkg::FlagC];
      adpe_pkg::OpSbc, adpe_pkg::OpRsc: begin
        add_b = ~op2_1_q;
        add_c = flags1_q[adpe_pkg::FlagC];
      end
      adpe_pkg::OpAdd, adpe_pkg::OpCmn: add_c = 1'b0;
      adpe_pkg::OpAnd, adpe_pkg::OpTst: begin
        arith     = 1'b0;
        logic_res = vn1_q & op2_1_q;
      end
      adpe_pkg::OpEor, adpe_pkg::OpTeq: begin
        arith     = 1'b0;
        logic_res = vn1_q ^ op2_1_q;
      end
      adpe_pkg::OpOrr: begin
        arith     = 1'b0;
        logic_res = vn1_q | op2_1_q;
      end
      adpe_pkg::OpMov: begin
        arith     = 1'b0;
        logic_res = op2_1_q;
      end
      adpe_pkg::OpBic: begin
        arith     = 1'b0;
        logic_res = vn1_q & ~op2_1_q;
      end
      default: begin
        arith     = 1'b0;
        logic_res = ~op2_1_q;
      end
    endcase
    sum_wide = {1'b0, add_a} + {1'b0, add_b} + {32'h0, add_c};
    sum      = sum_wide[31:0];
    ovf      = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);
    if (mov1_q) begin
      res2_d = movval1_q;
    end else if (arith) begin
      res2_d = sum;
    end else begin
      res2_d = logic_res;
    end
  end

  logic        v2_q, pass2_q, unh2_q, dp2_q, we2_q, s2_q, arith2_q;
  logic        carry2_q, ovf2_q, shco2_q;
  logic [3:0]  dest2_q, flags2_q;
  logic [31:0] res2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pass2_q  <= pass1_q;
    unh2_q   <= unh1_q;
    dp2_q    <= dp1_q;
    we2_q    <= we1_q;
    s2_q     <= s1_q;
    arith2_q <= arith;
    carry2_q <= sum_wide[32];
    ovf2_q   <= ovf;
    shco2_q  <= shco1_q;
    dest2_q  <= dest1_q;
    flags2_q <= flags1_q;
    res2_q   <= res2_d;
  end

  // ---------------- Stage three: flags and PC write ----------------
  logic [3:0]  flags_new, flags_d;
  logic [31:0] res_d;
  logic        pcw_d, thumb_d;

  always_comb begin
    flags_new[adpe_pkg::FlagN] = res2_q[31];
    flags_new[adpe_pkg::FlagZ] = (res2_q == 32'h0);
    flags_new[adpe_pkg::FlagC] = arith2_q ? carry2_q : shco2_q;
    flags_new[adpe_pkg::FlagV] = arith2_q ? ovf2_q : flags2_q[adpe_pkg::FlagV];
    flags_d = (dp2_q && s2_q) ? flags_new : flags2_q;
    pcw_d   = we2_q && (dest2_q == adpe_pkg::PcReg);
    thumb_d = pcw_d && res2_q[0];
    if (!we2_q) begin
      res_d = 32'h0;
    end else if (pcw_d) begin
      res_d = {res2_q[31:1], 1'b0};
    end else begin
      res_d = res2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_value_o     <= res_d;
    destination_o      <= dest2_q;
    write_enable_o     <= we2_q;
    flags_out_o        <= flags_d;
    condition_passed_o <= pass2_q;
    pc_written_o       <= pcw_d;
    thumb_next_o       <= thumb_d;
    unhandled_o        <= unh2_q;
  end

endmodule

// File: src/adpe_checker.sv
// Port-level checks for the A32 data-processing execute unit, bound to it.
// Depends on adpe_pkg for the PC register number.
module adpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        done_o,
  input logic [31:0] result_value_o,
  input logic [3:0]  destination_o,
  input logic        write_enable_o,
  input logic        condition_passed_o,
  input logic        pc_written_o,
  input logic        unhandled_o
);

  // Every result beat goes back to an earlier instruction taken with start high.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3))
    else $error("result beat without a matching instruction");

  a_fail_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !condition_passed_o) |->
      (!write_enable_o && !unhandled_o && !pc_written_o))
    else $error("failed condition produced an effect");

  a_pc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pc_written_o) |->
      (write_enable_o && !result_value_o[0] && destination_o == adpe_pkg::PcReg))
    else $error("inconsistent PC write");

  a_unhandled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unhandled_o) |-> (!write_enable_o && result_value_o == 32'h0))
    else $error("unhandled instruction wrote a result");

endmodule

bind arm_data_processing_execute_unit adpe_checker u_adpe_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .done_o             (done_o),
  .result_value_o     (result_value_o),
  .destination_o      (destination_o),
  .write_enable_o     (write_enable_o),
  .condition_passed_o (condition_passed_o),
  .pc_written_o       (pc_written_o),
  .unhandled_o        (unhandled_o)
);

// File: sim/tb_top.sv
// Testbench for the A32 data-processing execute unit: condition test, shifter, ALU, flags.
// Depends on adpe_pkg and arm_data_processing_execute_unit; a scoreboard class predicts each
// beat and checks the results in order, while plain tasks drive directed and random words.
module tb_top;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned CalmTail    = 100;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  dest;
    logic        we;
    logic [3:0]  flags;
    logic        pass;
    logic        pcw;
    logic        thumb;
    logic        unh;
  } dp_outcome_t;

  class dp_scoreboard;
    dp_outcome_t expected_outcomes[$];
    int unsigned mismatches;
    int unsigned compared;
    int unsigned skipped;
    int unsigned unhandled;
    int unsigned pc_writes;

    function logic condition_true(adpe_pkg::cond_e c, logic [3:0] f);
      logic n, z, cy, v, r;
      n  = f[adpe_pkg::FlagN];
      z  = f[adpe_pkg::FlagZ];
      cy = f[adpe_pkg::FlagC];
      v  = f[adpe_pkg::FlagV];
      case (c)
        adpe_pkg::CondEq: r = z;
        adpe_pkg::CondNe: r = !z;
        adpe_pkg::CondCs: r = cy;
        adpe_pkg::CondCc: r = !cy;
        adpe_pkg::CondMi: r = n;
        adpe_pkg::CondPl: r = !n;
        adpe_pkg::CondVs: r = v;
        adpe_pkg::CondVc: r = !v;
        adpe_pkg::CondHi: r = cy && !z;
        adpe_pkg::CondLs: r = !cy || z;
        adpe_pkg::CondGe: r = (n == v);
        adpe_pkg::CondLt: r = (n != v);
        adpe_pkg::CondGt: r = !z && (n == v);
        adpe_pkg::CondLe: r = z || (n != v);
        default:          r = 1'b1;
      endcase
      return r;
    endfunction

    // Immediate-amount shifter; a zero amount means a shift by 32 for LSR and ASR, RRX for ROR.
    function logic [31:0] barrel_shift(input logic [31:0] v, input adpe_pkg::shift_e kind,
                                       input logic [4:0] amt, input logic cin,
                                       output logic cout);
      logic [63:0] w;
      logic [31:0] r;
      cout = cin;
      r = v;
      case (kind)
        adpe_pkg::ShLsl: if (amt != 5'd0) begin
          cout = v[32 - int'(amt)];
          r = v << amt;
        end
        adpe_pkg::ShLsr: if (amt == 5'd0) begin
          cout = v[31];
          r = '0;
        end else begin
          cout = v[int'(amt) - 1];
          r = v >> amt;
        end
        adpe_pkg::ShAsr: if (amt == 5'd0) begin
          cout = v[31];
          r = {32{v[31]}};
        end else begin
          w = {{32{v[31]}}, v} >> amt;
          cout = v[int'(amt) - 1];
          r = w[31:0];
        end
        default: if (amt == 5'd0) begin
          cout = v[0];
          r = {cin, v[31:1]};
        end else begin
          w = {v, v} >> amt;
          cout = v[int'(amt) - 1];
          r = w[31:0];
        end
      endcase
      return r;
    endfunction

    function logic [31:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                         input logic cin, output logic [3:0] nzcv);
      logic [32:0] sum;
      logic [31:0] r;
      sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      r = sum[31:0];
      nzcv = {r[31], r == 32'd0, sum[32], (a[31] ^ r[31]) & (b[31] ^ r[31])};
      return r;
    endfunction

    function dp_outcome_t execute_a32(input logic [31:0] insn, input logic [31:0] vn,
                                      input logic [31:0] vm, input logic [31:0] old,
                                      input logic [3:0] f);
      dp_outcome_t o;
      adpe_pkg::cond_e c;
      adpe_pkg::op_e op;
      logic s, imm_form, arith, shco;
      logic [4:0] rot;
      logic [63:0] w;
      logic [31:0] opnd;
      logic [3:0] nf;
      logic [15:0] imm16;
      c = adpe_pkg::cond_e'(insn[31:28]);
      o = '0;
      o.dest = insn[15:12];
      o.flags = f;
      o.pass = 1'b1;
      if (c != adpe_pkg::CondNv && !condition_true(c, f)) begin
        o.pass = 1'b0;
      end else if (c == adpe_pkg::CondNv) begin
        o.unh = 1'b1;
      end else if ((insn & adpe_pkg::MovMask) == adpe_pkg::MovMatch) begin
        imm16 = {insn[19:16], insn[11:0]};
        o.value = insn[22] ? {imm16, old[15:0]} : {16'h0000, imm16};
        o.we = 1'b1;
      end else if (insn[27:26] != 2'b00) begin
        o.unh = 1'b1;
      end else begin
        op = adpe_pkg::op_e'(insn[24:21]);
        s = insn[20];
        imm_form = insn[25];
        if ((op >= adpe_pkg::OpTst && op <= adpe_pkg::OpCmn && !s) ||
            (!imm_form && insn[4]) || op == adpe_pkg::OpRsc) begin
          o.unh = 1'b1;
        end else begin
          shco = f[adpe_pkg::FlagC];
          nf = f;
          arith = 1'b1;
          if (imm_form) begin
            rot = {insn[11:8], 1'b0};
            w = {24'd0, insn[7:0], 24'd0, insn[7:0]} >> rot;
            opnd = w[31:0];
            if (rot != 5'd0) shco = opnd[31];
          end else begin
            opnd = barrel_shift(vm, adpe_pkg::shift_e'(insn[6:5]), insn[11:7],
                                f[adpe_pkg::FlagC], shco);
          end
          o.we = 1'b1;
          case (op)
            adpe_pkg::OpAnd: begin o.value = vn & opnd; arith = 1'b0; end
            adpe_pkg::OpEor: begin o.value = vn ^ opnd; arith = 1'b0; end
            adpe_pkg::OpSub: o.value = add_with_carry(vn, ~opnd, 1'b1, nf);
            adpe_pkg::OpRsb: o.value = add_with_carry(~vn, opnd, 1'b1, nf);
            adpe_pkg::OpAdd: o.value = add_with_carry(vn, opnd, 1'b0, nf);
            adpe_pkg::OpAdc: o.value = add_with_carry(vn, opnd, f[adpe_pkg::FlagC], nf);
            adpe_pkg::OpSbc: o.value = add_with_carry(vn, ~opnd, f[adpe_pkg::FlagC], nf);
            adpe_pkg::OpTst: begin o.value = vn & opnd; arith = 1'b0; o.we = 1'b0; end
            adpe_pkg::OpTeq: begin o.value = vn ^ opnd; arith = 1'b0; o.we = 1'b0; end
            adpe_pkg::OpCmp: begin
              o.value = add_with_carry(vn, ~opnd, 1'b1, nf);
              o.we = 1'b0;
            end
            adpe_pkg::OpCmn: begin
              o.value = add_with_carry(vn, opnd, 1'b0, nf);
              o.we = 1'b0;
            end
            adpe_pkg::OpOrr: begin o.value = vn | opnd; arith = 1'b0; end
            adpe_pkg::OpMov: begin o.value = opnd; arith = 1'b0; end
            adpe_pkg::OpBic: begin o.value = vn & ~opnd; arith = 1'b0; end
            default: begin o.value = ~opnd; arith = 1'b0; end
          endcase
          if (s) begin
            o.flags = arith ? nf
                            : {o.value[31], o.value == 32'd0, shco, f[adpe_pkg::FlagV]};
          end
          if (!o.we) o.value = '0;
        end
      end
      if (o.we && o.dest == adpe_pkg::PcReg) begin
        o.pcw = 1'b1;
        o.thumb = o.value[0];
        o.value[0] = 1'b0;
      end
      return o;
    endfunction

    function void note_instruction(input logic [31:0] insn, input logic [31:0] vn,
                                   input logic [31:0] vm, input logic [31:0] old,
                                   input logic [3:0] f);
      dp_outcome_t o;
      o = execute_a32(insn, vn, vm, old, f);
      expected_outcomes.push_back(o);
      if (!o.pass) skipped++;
      if (o.unh) unhandled++;
      if (o.pcw) pc_writes++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(dp_outcome_t got);
      dp_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result beat arrived with no instruction outstanding");
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      compared++;
      compare_field("result_value", want.value, got.value);
      compare_field("destination", 32'(want.dest), 32'(got.dest));
      compare_field("write_enable", 32'(want.we), 32'(got.we));
      compare_field("flags_out", 32'(want.flags), 32'(got.flags));
      compare_field("condition_passed", 32'(want.pass), 32'(got.pass));
      compare_field("pc_written", 32'(want.pcw), 32'(got.pcw));
      compare_field("thumb_next", 32'(want.thumb), 32'(got.thumb));
      compare_field("unhandled", 32'(want.unh), 32'(got.unh));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] instruction_i = '0;
  logic [31:0] first_operand_i = '0;
  logic [31:0] shift_operand_i = '0;
  logic [31:0] old_destination_i = '0;
  logic [3:0]  flags_in_i = '0;
  logic        done_o;
  logic [31:0] result_value_o;
  logic [3:0]  destination_o;
  logic        write_enable_o;
  logic [3:0]  flags_out_o;
  logic        condition_passed_o;
  logic        pc_written_o;
  logic        thumb_next_o;
  logic        unhandled_o;

  dp_scoreboard sb = new();
  int unsigned cycle_count = 0;

  arm_data_processing_execute_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .instruction_i      (instruction_i),
    .first_operand_i    (first_operand_i),
    .shift_operand_i    (shift_operand_i),
    .old_destination_i  (old_destination_i),
    .flags_in_i         (flags_in_i),
    .done_o             (done_o),
    .result_value_o     (result_value_o),
    .destination_o      (destination_o),
    .write_enable_o     (write_enable_o),
    .flags_out_o        (flags_out_o),
    .condition_passed_o (condition_passed_o),
    .pc_written_o       (pc_written_o),
    .thumb_next_o       (thumb_next_o),
    .unhandled_o        (unhandled_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Accepted beats go into the scoreboard before any result of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_instruction(instruction_i, first_operand_i, shift_operand_i,
                            old_destination_i, flags_in_i);
      end
      if (done_o) begin
        sb.check_result('{result_value_o, destination_o, write_enable_o, flags_out_o,
                          condition_passed_o, pc_written_o, thumb_next_o, unhandled_o});
      end
    end
  end

  function automatic logic [31:0] extreme_value(int k);
    case (k % 4)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_operand();
    if ($urandom_range(0, 3) == 0) return extreme_value(int'($urandom_range(0, 3)));
    return $urandom();
  endfunction

  function automatic logic [31:0] dp_word(adpe_pkg::cond_e c, logic i, adpe_pkg::op_e op,
                                          logic s, logic [3:0] rn, logic [3:0] rd,
                                          logic [11:0] op2);
    return {c, 2'b00, i, op, s, rn, rd, op2};
  endfunction

  function automatic logic [31:0] mov_wide(adpe_pkg::cond_e c, logic top, logic [3:0] rd,
                                           logic [15:0] imm16);
    return {c, 4'b0011, 1'b0, top, 2'b00, imm16[15:12], rd, imm16[11:0]};
  endfunction

  // Mostly well-formed data-processing words with random fields, some MOVW/MOVT, some noise.
  function automatic logic [31:0] random_insn();
    logic [3:0]  c;
    logic [11:0] op2;
    logic        i;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    c = ($urandom_range(0, 2) == 0) ? 4'($urandom()) : adpe_pkg::CondAl;
    if (pick == 0) begin
      return {c, 4'b0011, 1'b0, 1'($urandom()), 2'b00, 4'($urandom()), 4'($urandom()),
              12'($urandom())};
    end
    if (pick <= 2) return $urandom();
    i = 1'($urandom());
    if (i) begin
      op2 = 12'($urandom());
    end else begin
      op2 = {($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom()), 2'($urandom()),
             ($urandom_range(0, 11) == 0), 4'($urandom())};
    end
    return {c, 2'b00, i, 4'($urandom()), ($urandom_range(0, 4) != 0), 4'($urandom()),
            4'($urandom()), op2};
  endfunction

  task automatic drive_beat(input logic [31:0] insn, input logic [31:0] vn,
                            input logic [31:0] vm, input logic [31:0] old,
                            input logic [3:0] f);
    @(negedge clk_i);
    start <= 1'b1;
    instruction_i <= insn;
    first_operand_i <= vn;
    shift_operand_i <= vm;
    old_destination_i <= old;
    flags_in_i <= f;
    do @(posedge clk_i); while (busy);
  endtask

  // Idle cycles carry junk on the data inputs, which the block must ignore.
  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      instruction_i <= $urandom();
      first_operand_i <= $urandom();
      shift_operand_i <= $urandom();
      old_destination_i <= $urandom();
      flags_in_i <= 4'($urandom());
    end
  endtask

  task automatic wait_quiet();
    while (sb.expected_outcomes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic gaps_on;
    gaps_on = 1'b1;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every opcode with S set; the shift kind follows the opcode, always by zero.
    for (int k = 0; k < 16; k++) begin
      drive_beat(dp_word(adpe_pkg::CondAl, 1'b0, adpe_pkg::op_e'(k), 1'b1, 4'($urandom()),
                         (k == 15) ? adpe_pkg::PcReg : 4'($urandom()),
                         {5'd0, 2'(k), 1'b0, 4'($urandom())}),
                 extreme_value(k), extreme_value(k + 1), $urandom(),
                 (k % 2 == 1) ? 4'hF : 4'h0);
    end
    drive_beat(dp_word(adpe_pkg::CondAl, 1'b1, adpe_pkg::OpAnd, 1'b1, 4'h1, 4'h2, 12'h0FF),
               32'hFFFF_FFFF, $urandom(), $urandom(), 4'b0010);
    drive_beat(dp_word(adpe_pkg::CondAl, 1'b1, adpe_pkg::OpMov, 1'b1, 4'h0, 4'h1, 12'h102),
               $urandom(), $urandom(), $urandom(), 4'b0000);
    drive_beat(dp_word(adpe_pkg::CondAl, 1'b0, adpe_pkg::OpTst, 1'b0, 4'h4, 4'h5, 12'h006),
               $urandom(), $urandom(), $urandom(), 4'hF);
    drive_beat(dp_word(adpe_pkg::CondAl, 1'b0, adpe_pkg::OpAdd, 1'b1, 4'h6, 4'h7,
                       {4'h3, 1'b0, adpe_pkg::ShLsl, 1'b1, 4'h2}),
               $urandom(), $urandom(), $urandom(), 4'h0);
    drive_beat(dp_word(adpe_pkg::CondNv, 1'b0, adpe_pkg::OpMov, 1'b1, 4'h0, 4'h8, 12'h001),
               $urandom(), $urandom(), $urandom(), 4'h0);
    drive_beat({adpe_pkg::CondAl, 8'b0101_1001, 20'($urandom())}, $urandom(), $urandom(),
               $urandom(), 4'h0);
    drive_beat(mov_wide(adpe_pkg::CondAl, 1'b0, adpe_pkg::PcReg, 16'hABCD), $urandom(),
               $urandom(), $urandom(), 4'h0);
    drive_beat(mov_wide(adpe_pkg::CondAl, 1'b1, 4'h3, 16'hFFFF), $urandom(), $urandom(),
               32'h1234_5678, 4'h0);
    drive_beat(dp_word(adpe_pkg::CondEq, 1'b1, adpe_pkg::OpMov, 1'b1, 4'h0, 4'h9, 12'h0FF),
               $urandom(), $urandom(), $urandom(), 4'b1011);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == RandomItems / 2) begin
        hold_off(1);
        wait_quiet();
      end
      if (gaps_on && n < RandomItems - CalmTail && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 19));
      end
      drive_beat(random_insn(), pick_operand(), pick_operand(), pick_operand(),
                 4'($urandom()));
    end

    hold_off(1);
    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Compared %0d result beats: %0d held back by condition, %0d unhandled,",
             sb.compared, sb.skipped, sb.unhandled);
    $display("and %0d PC writes, over directed opcodes, shifts, MOVW/MOVT and random words.",
             sb.pc_writes);
    if (sb.mismatches == 0 && sb.expected_outcomes.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/adpe_pkg.sv
src/arm_data_processing_execute_unit.sv
src/adpe_checker.sv
sim/tb_top.sv
